>>> src/bts_pkg.sv
// Package for the bounded value table: field widths, operation codes and
// the control struct that the top level hands to the cell chain.
// No dependencies.
package bts_pkg;

  // Field widths
  localparam int VAL_W       = 32;
  localparam int KIND_W      = 2;
  localparam int IDX_FIELD_W = 6;
  localparam int FILL_W      = 6;

  // Table size and slice length limit
  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SLICE  = 2'd2;

  // Write commands broadcast to every cell
  typedef struct packed {
    logic ins_we;   // append key at index count
    logic swap_we;  // overwrite the first match with the last entry
  } cell_ctl_t;

endpackage

>>> src/bts_cell.sv
// One table cell: holds a single entry, compares it with the key and joins
// the match, last-entry and read chains. Depends on bts_pkg.
module bts_cell import bts_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CMP_W = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] key,
  input  logic [VAL_W-1:0] swap_data,
  input  logic [CMP_W-1:0] count,
  input  logic [CMP_W-1:0] rd_idx,
  input  logic             found_in,
  output logic             found_out,
  input  logic [VAL_W-1:0] last_in,
  output logic [VAL_W-1:0] last_out,
  input  logic [VAL_W-1:0] rd_in,
  output logic [VAL_W-1:0] rd_out
);

  localparam logic [CMP_W-1:0] MY_IDX   = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] LAST_POS = CMP_W'(IDX + 1);

  logic [VAL_W-1:0] entry;
  logic             hit;
  logic             first;

  // Compare against the key; only entries below the fill count take part
  assign hit       = (MY_IDX < count) && (entry == key);
  assign first     = hit && !found_in;
  assign found_out = found_in | hit;

  // Pass the last valid entry and the addressed entry down the chain
  assign last_out = last_in | ((count == LAST_POS) ? entry : '0);
  assign rd_out   = rd_in | ((rd_idx == MY_IDX) ? entry : '0);

  // Append or take the swapped-in entry
  always_ff @(posedge clk) begin
    if (ctl.ins_we && (count == MY_IDX)) begin
      entry <= key;
    end else if (ctl.swap_we && first) begin
      entry <= swap_data;
    end
  end

endmodule

>>> src/bts_table.sv
// Row of table cells chained by index: match priority, last-entry and
// read-out chains. Depends on bts_pkg and bts_cell.
module bts_table import bts_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CMP_W    = 6
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] key,
  input  logic [CMP_W-1:0] count,
  input  logic [CMP_W-1:0] rd_idx,
  output logic             any_match,
  output logic [VAL_W-1:0] last_data,
  output logic [VAL_W-1:0] rd_data
);

  logic [CAPACITY:0]            found_c;
  logic [CAPACITY:0][VAL_W-1:0] last_c;
  logic [CAPACITY:0][VAL_W-1:0] rd_c;

  assign found_c[0] = 1'b0;
  assign last_c[0]  = '0;
  assign rd_c[0]    = '0;

  // Build the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bts_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key),
      .swap_data (last_data),
      .count     (count),
      .rd_idx    (rd_idx),
      .found_in  (found_c[i]),
      .found_out (found_c[i+1]),
      .last_in   (last_c[i]),
      .last_out  (last_c[i+1]),
      .rd_in     (rd_c[i]),
      .rd_out    (rd_c[i+1])
    );
  end

  assign any_match = found_c[CAPACITY];
  assign last_data = last_c[CAPACITY];
  assign rd_data   = rd_c[CAPACITY];

endmodule

>>> src/bounded_table_insert_remove_slice.sv
// Bounded unordered value table with insert, swap-remove and slice readout.
// Insert, unused codes and empty slices: one result, from the EXEC state. Remove: EXEC
// takes out the lowest match, and with duplicates on repeats until none is left. Slice:
// EXEC sets up the range, then one entry per cycle from S_SLICE; results cannot stall.
// Busy drops with the final result; the next start is taken in that cycle.
// Synchronous reset empties the table and sets allow_duplicates to 1.
module bounded_table_insert_remove_slice import bts_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      kind,
  input  logic signed [VAL_W-1:0] value,
  input  logic [IDX_FIELD_W-1:0] range_from,
  input  logic [IDX_FIELD_W-1:0] range_to,
  output logic                   done,
  output logic                   success,
  output logic                   has_element,
  output logic signed [VAL_W-1:0] element,
  output logic [FILL_W-1:0]      fill_count,
  output logic                   last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SLICE
  } state_t;

  state_t                 state;
  logic                   allow_dup;
  logic [CNT_W-1:0]       count;
  logic [KIND_W-1:0]      op_kind;
  logic [VAL_W-1:0]       op_value;
  logic [IDX_FIELD_W-1:0] op_from;
  logic [IDX_FIELD_W-1:0] op_to;
  logic                   found;
  logic [CMP_W-1:0]       rd_idx;
  logic [CMP_W-1:0]       end_idx;
  logic [RES_CNT_W-1:0]   n_out;

  cell_ctl_t              ctl;
  logic                   any_match;
  logic [VAL_W-1:0]       last_data;
  logic [VAL_W-1:0]       rd_data;
  logic [CMP_W-1:0]       count_x;
  logic [CMP_W-1:0]       from_x;
  logic [CMP_W-1:0]       to_x;
  logic                   ins_ok;
  logic                   slice_last;

  assign busy    = (state != S_IDLE);
  assign count_x = CMP_W'(count);
  assign from_x  = CMP_W'(op_from);
  assign to_x    = CMP_W'(op_to);

  assign ins_ok     = (count < CNT_W'(CAPACITY)) && (allow_dup || !any_match);
  assign slice_last = (rd_idx == end_idx) || (n_out == RES_CNT_W'(MAX_RESULTS - 1));

  // Drive cell writes for the current step
  always_comb begin
    ctl.ins_we  = 1'b0;
    ctl.swap_we = 1'b0;
    if (state == S_EXEC) begin
      case (op_kind)
        KIND_INSERT: ctl.ins_we  = ins_ok;
        KIND_REMOVE: ctl.swap_we = any_match;
        default:     ctl.ins_we  = 1'b0;
      endcase
    end
  end

  bts_table #(
    .CAPACITY (CAPACITY),
    .CMP_W    (CMP_W)
  ) u_table (
    .clk       (clk),
    .ctl       (ctl),
    .key       (op_value),
    .count     (count_x),
    .rd_idx    (rd_idx),
    .any_match (any_match),
    .last_data (last_data),
    .rd_data   (rd_data)
  );

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_dup <= 1'b1;
    end else if (cfg_we) begin
      allow_dup <= cfg_wdata;
    end
  end

  // Sequence each transaction and register the results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_kind  <= kind;
            op_value <= value;
            op_from  <= range_from;
            op_to    <= range_to;
            found    <= 1'b0;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          has_element <= 1'b0;
          element     <= '0;
          last        <= 1'b1;
          case (op_kind)
            KIND_INSERT: begin
              if (ins_ok) begin
                count <= count + CNT_W'(1);
              end
              done       <= 1'b1;
              success    <= ins_ok;
              fill_count <= ins_ok ? FILL_W'(count + CNT_W'(1)) : FILL_W'(count);
              state      <= S_IDLE;
            end
            KIND_REMOVE: begin
              // Remove the lowest match; re-check while duplicates are on
              if (any_match) begin
                count <= count - CNT_W'(1);
                found <= 1'b1;
                if (!allow_dup) begin
                  done       <= 1'b1;
                  success    <= 1'b1;
                  fill_count <= FILL_W'(count - CNT_W'(1));
                  state      <= S_IDLE;
                end
              end else begin
                done       <= 1'b1;
                success    <= found;
                fill_count <= FILL_W'(count);
                state      <= S_IDLE;
              end
            end
            KIND_SLICE: begin
              fill_count <= FILL_W'(count);
              if ((from_x >= count_x) || (op_from > op_to)) begin
                done    <= 1'b1;
                success <= 1'b1;
                state   <= S_IDLE;
              end else begin
                rd_idx  <= from_x;
                end_idx <= (to_x < count_x) ? to_x : (count_x - CMP_W'(1));
                n_out   <= '0;
                state   <= S_SLICE;
              end
            end
            default: begin
              done       <= 1'b1;
              success    <= 1'b0;
              fill_count <= FILL_W'(count);
              state      <= S_IDLE;
            end
          endcase
        end
        S_SLICE: begin
          // Advance one entry per cycle
          done        <= 1'b1;
          success     <= 1'b1;
          has_element <= 1'b1;
          element     <= rd_data;
          last        <= slice_last;
          rd_idx      <= rd_idx + CMP_W'(1);
          n_out       <= n_out + RES_CNT_W'(1);
          if (slice_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Fill count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CNT_W'(1)
                     || count + CNT_W'(1) == $past(count)))
    else $error("fill count jumped");

  // Final result releases busy; earlier results keep it
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> (last == !busy))
    else $error("busy does not match last marker");

  // Busy drops only with the final result of a transaction
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (done && last))
    else $error("busy fell without final result");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the bounded value table: directed and random
// insert, remove, slice and unused-code transactions checked by a scoreboard.
// Depends on bts_pkg and bounded_table_insert_remove_slice.
module testbench;
  import bts_pkg::*;

  // The one code the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic             ok;
    logic             has;
    logic [VAL_W-1:0] elem;
    logic [FILL_W-1:0] fill;
    logic             lst;
  } table_result_t;

  // Table predictor plus the queue of results it has promised
  class table_scoreboard;
    logic [VAL_W-1:0] slots [CAPACITY_DEF];
    int unsigned      fill;
    bit               dup_ok;
    int               errors;
    table_result_t    pending_results[$];

    function new();
      fill = 0;
      dup_ok = 1'b1;
      errors = 0;
    endfunction

    function void queue_result(bit ok, bit has, logic [VAL_W-1:0] elem, bit lst);
      table_result_t r;
      r.ok = ok;
      r.has = has;
      r.elem = elem;
      r.fill = FILL_W'(fill);
      r.lst = lst;
      pending_results.push_back(r);
    endfunction

    function bit insert_value(logic [VAL_W-1:0] v);
      if (fill >= CAPACITY_DEF) return 1'b0;
      if (!dup_ok) begin
        for (int unsigned i = 0; i < fill; i++)
          if (slots[i] == v) return 1'b0;
      end
      slots[fill] = v;
      fill++;
      return 1'b1;
    endfunction

    // Swap the last entry into each freed slot and look at that slot again
    function bit remove_value(logic [VAL_W-1:0] v);
      int unsigned i;
      bit found;
      i = 0;
      found = 1'b0;
      if (fill == 0) return 1'b0;
      while (i < fill) begin
        if (slots[i] == v) begin
          fill--;
          slots[i] = slots[fill];
          found = 1'b1;
          if (!dup_ok) return 1'b1;
        end else begin
          i++;
        end
      end
      return found;
    endfunction

    // Update the table for one accepted transaction and queue its results
    function void apply_op(logic [KIND_W-1:0] op, logic [VAL_W-1:0] v,
                           logic [IDX_FIELD_W-1:0] from, logic [IDX_FIELD_W-1:0] to);
      bit ok;
      int unsigned last_idx;
      int n;
      case (op)
        KIND_INSERT: begin
          ok = insert_value(v);
          queue_result(ok, 1'b0, '0, 1'b1);
        end
        KIND_REMOVE: begin
          ok = remove_value(v);
          queue_result(ok, 1'b0, '0, 1'b1);
        end
        KIND_SLICE: begin
          if (from >= fill || from > to) begin
            queue_result(1'b1, 1'b0, '0, 1'b1);
          end else begin
            last_idx = (to < fill) ? to : fill - 1;
            n = 0;
            for (int unsigned i = from; i <= last_idx && n < MAX_RESULTS; i++) begin
              queue_result(1'b1, 1'b1, slots[i], (i == last_idx) || (n == MAX_RESULTS - 1));
              n++;
            end
          end
        end
        default: queue_result(1'b0, 1'b0, '0, 1'b1);
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
    endtask

    // Compare one result against the oldest promised one, field by field
    task check_result(logic ok, logic has, logic [VAL_W-1:0] elem,
                      logic [FILL_W-1:0] fill_o, logic lst);
      table_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, element %h", elem));
        return;
      end
      want = pending_results.pop_front();
      if (ok !== want.ok)
        report($sformatf("success %b, want %b", ok, want.ok));
      if (has !== want.has)
        report($sformatf("has_element %b, want %b", has, want.has));
      if (elem !== want.elem)
        report($sformatf("element %h, want %h", elem, want.elem));
      if (fill_o !== want.fill)
        report($sformatf("fill_count %0d, want %0d", fill_o, want.fill));
      if (lst !== want.lst)
        report($sformatf("last %b, want %b", lst, want.lst));
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic                    cfg_wdata;
  logic                    start;
  logic                    busy;
  logic [KIND_W-1:0]       kind;
  logic [VAL_W-1:0]        value;
  logic [IDX_FIELD_W-1:0]  range_from;
  logic [IDX_FIELD_W-1:0]  range_to;
  logic                    done;
  logic                    success;
  logic                    has_element;
  logic [VAL_W-1:0]        element;
  logic [FILL_W-1:0]       fill_count;
  logic                    last;

  table_scoreboard sb;

  bounded_table_insert_remove_slice dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .value       (value),
    .range_from  (range_from),
    .range_to    (range_to),
    .done        (done),
    .success     (success),
    .has_element (has_element),
    .element     (element),
    .fill_count  (fill_count),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every strobed result at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(success, has_element, element, fill_count, last);
  end

  // Present one transaction and hold it until the block takes it
  task automatic send_op(logic [KIND_W-1:0] op, logic [VAL_W-1:0] v,
                         logic [IDX_FIELD_W-1:0] from, logic [IDX_FIELD_W-1:0] to);
    @(negedge clk);
    start <= 1'b1;
    kind <= op;
    value <= v;
    range_from <= from;
    range_to <= to;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.apply_op(op, v, from, to);
  endtask

  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Change the duplicate mode only with the block idle
  task automatic write_dup_mode(bit mode);
    pause_sender(1);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    sb.dup_ok = mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a small pool of values so that matches and duplicates occur
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 7))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0000;
        4: return 32'h0000_0001;
        5: return 32'h5A5A_5A5A;
        6: return 32'hA5A5_A5A5;
        default: return 32'h0000_0100;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_op(int ins_pct);
    logic [KIND_W-1:0] op;
    int f;
    int t;
    int pick;
    if ($urandom_range(0, 99) < ins_pct) begin
      op = KIND_INSERT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) op = KIND_UNUSED;
      else if (pick < 8) op = KIND_SLICE;
      else op = KIND_REMOVE;
    end
    // Aim most slices at the filled part of the table
    if ($urandom_range(0, 3) != 0) begin
      f = $urandom_range(0, sb.fill);
      t = f + $urandom_range(0, 40);
      if (t > 63) t = 63;
    end else begin
      f = $urandom_range(0, 63);
      t = $urandom_range(0, 63);
    end
    send_op(op, pick_value(), IDX_FIELD_W'(f), IDX_FIELD_W'(t));
  endtask

  // Send bursts of random length with random gaps between them
  task automatic run_phase(int items, int ins_pct);
    int left;
    int burst;
    left = items;
    while (left > 0) begin
      burst = $urandom_range(1, 10);
      if (burst > left) burst = left;
      repeat (burst) random_op(ins_pct);
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    start <= 1'b0;
    kind <= KIND_INSERT;
    value <= '0;
    range_from <= '0;
    range_to <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused code, extremes, duplicates, slice edges
    send_op(KIND_SLICE, 32'h0, 6'd0, 6'd63);
    send_op(KIND_REMOVE, 32'h0, 6'd0, 6'd0);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_op(KIND_INSERT, 32'h8000_0000, 6'd0, 6'd0);
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 6'd63, 6'd0);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 6'd0, 6'd63);
    send_op(KIND_INSERT, 32'h0, 6'd0, 6'd0);
    send_op(KIND_INSERT, 32'h0, 6'd0, 6'd0);
    send_op(KIND_INSERT, 32'h0, 6'd0, 6'd0);
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send_op(KIND_SLICE, 32'h0, 6'd0, 6'd63);
    send_op(KIND_SLICE, 32'h0, 6'd2, 6'd2);
    send_op(KIND_SLICE, 32'h0, 6'd5, 6'd2);
    send_op(KIND_SLICE, 32'h0, 6'd63, 6'd63);
    send_op(KIND_REMOVE, 32'h0, 6'd0, 6'd0);
    send_op(KIND_REMOVE, 32'h0000_1234, 6'd0, 6'd0);
    send_op(KIND_SLICE, 32'h0, 6'd0, 6'd63);
    send_op(KIND_REMOVE, 32'hFFFF_FFFF, 6'd0, 6'd0);

    // Duplicates off: repeated values are refused, a remove drops one match
    write_dup_mode(1'b0);
    send_op(KIND_INSERT, 32'h8000_0000, 6'd0, 6'd0);
    send_op(KIND_INSERT, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send_op(KIND_REMOVE, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send_op(KIND_SLICE, 32'h0, 6'd0, 6'd63);
    run_phase(50, 60);

    // Insert-heavy with duplicates on to reach a full table
    write_dup_mode(1'b1);
    run_phase(60, 85);

    // Duplicates off over a table that may still hold duplicates
    write_dup_mode(1'b0);
    run_phase(40, 30);

    write_dup_mode(1'b1);
    run_phase(50, 40);

    // Drain and allow for stray results
    pause_sender(1);
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> bounded_table_insert_remove_slice.f
src/bts_pkg.sv
src/bts_cell.sv
src/bts_table.sv
src/bounded_table_insert_remove_slice.sv
tb/sv/testbench.sv
